/* hw/rtl/kmd_pkg.sv */
// ----------------------------------------------------------------------------
// kmd_pkg
// Types, sizes and helpers shared by the key matrix debounce block.
// ----------------------------------------------------------------------------
package kmd_pkg;

    localparam int ROW_COUNT    = 6;
    localparam int COLUMN_COUNT = 17;

    localparam int ROW_W   = 3;
    localparam int COL_W   = COLUMN_COUNT;
    localparam int QCOL_W  = 5;
    localparam int COUNT_W = 8;
    localparam int POP_W   = $clog2(COLUMN_COUNT + 1);
    localparam int TOTAL_W = 7;

    localparam logic [COUNT_W-1:0] SETTLE_RESET = COUNT_W'(5);

    typedef struct packed {
        logic [ROW_W-1:0]  row_index;
        logic [COL_W-1:0]  column_pins_n;
        logic              pass_end;
        logic [QCOL_W-1:0] query_column;
    } kmd_item_t;

    typedef struct packed {
        logic [COL_W-1:0]   stable_row;
        logic               key_on;
        logic               settled;
        logic               bounce_seen;
        logic [TOTAL_W-1:0] pressed_total;
    } kmd_result_t;

    function automatic logic [POP_W-1:0] count_ones(input logic [COL_W-1:0] v);
        logic [POP_W-1:0] n;
        n = '0;
        for (int i = 0; i < COL_W; i++)
        begin
            n = n + POP_W'(v[i]);
        end
        return n;
    endfunction

endpackage

/* hw/rtl/kmd_core.sv */
// ----------------------------------------------------------------------------
// kmd_core
// Pending and stable matrix state, settle counter and result logic.
// ----------------------------------------------------------------------------
module kmd_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [kmd_pkg::COUNT_W-1:0]        cfg_data,
    input  logic                               advance,
    input  kmd_pkg::kmd_item_t                 item,
    output kmd_pkg::kmd_result_t               result
);

    logic [kmd_pkg::COL_W-1:0]   pending_reg [kmd_pkg::ROW_COUNT];
    logic [kmd_pkg::COL_W-1:0]   pending_next [kmd_pkg::ROW_COUNT];
    logic [kmd_pkg::COL_W-1:0]   stable_reg [kmd_pkg::ROW_COUNT];
    logic [kmd_pkg::COL_W-1:0]   stable_next [kmd_pkg::ROW_COUNT];
    logic [kmd_pkg::COUNT_W-1:0] count_reg, count_next, count_mid;
    logic [kmd_pkg::COUNT_W-1:0] passes_reg;
    logic [kmd_pkg::TOTAL_W-1:0] pend_total_reg, pend_total_next;
    logic [kmd_pkg::TOTAL_W-1:0] stable_total_reg, stable_total_next;

    logic                        row_ok;
    logic [kmd_pkg::COL_W-1:0]   pressed;
    logic [kmd_pkg::COL_W-1:0]   old_row;
    logic [kmd_pkg::COL_W-1:0]   srow;
    logic                        changed;
    logic                        dec;
    logic                        commit;

    always_comb
    begin
        row_ok  = item.row_index < kmd_pkg::ROW_W'(kmd_pkg::ROW_COUNT);
        pressed = ~item.column_pins_n;
        old_row = row_ok ? pending_reg[item.row_index] : '0;
        changed = row_ok && (old_row != pressed);

        pending_next = pending_reg;
        if (changed)
        begin
            pending_next[item.row_index] = pressed;
        end

        // a zero setting behaves as one pass
        if (changed)
        begin
            count_mid = (passes_reg != '0) ? passes_reg : kmd_pkg::COUNT_W'(1);
        end
        else
        begin
            count_mid = count_reg;
        end

        dec        = item.pass_end && (count_mid != '0);
        count_next = dec ? count_mid - kmd_pkg::COUNT_W'(1) : count_mid;
        commit     = dec && (count_next == '0);

        pend_total_next = pend_total_reg;
        if (changed)
        begin
            pend_total_next = pend_total_reg
                            + kmd_pkg::TOTAL_W'(kmd_pkg::count_ones(pressed))
                            - kmd_pkg::TOTAL_W'(kmd_pkg::count_ones(old_row));
        end

        stable_next       = commit ? pending_next : stable_reg;
        stable_total_next = commit ? pend_total_next : stable_total_reg;

        srow = row_ok ? stable_next[item.row_index] : '0;

        result.stable_row    = srow;
        result.key_on        = (item.query_column < kmd_pkg::QCOL_W'(kmd_pkg::COLUMN_COUNT))
                               ? srow[item.query_column] : 1'b0;
        result.settled       = (count_next == '0);
        result.bounce_seen   = changed && (count_reg != '0);
        result.pressed_total = stable_total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < kmd_pkg::ROW_COUNT; r++)
            begin
                pending_reg[r] <= '0;
                stable_reg[r]  <= '0;
            end
            count_reg        <= kmd_pkg::SETTLE_RESET;
            passes_reg       <= kmd_pkg::SETTLE_RESET;
            pend_total_reg   <= '0;
            stable_total_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                passes_reg <= cfg_data;
            end
            if (advance)
            begin
                pending_reg      <= pending_next;
                stable_reg       <= stable_next;
                count_reg        <= count_next;
                pend_total_reg   <= pend_total_next;
                stable_total_reg <= stable_total_next;
            end
        end
    end

    // state only moves with a request
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(count_reg) && $stable(stable_total_reg))
    else $error("kmd_core: state changed without a request");

    // after a commit the stable matrix matches the pending one
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && commit) |=> (stable_total_reg == pend_total_reg) && (count_reg == '0))
    else $error("kmd_core: commit left totals or counter inconsistent");

    // a settled counter stays settled until a row changes
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !changed && count_reg == '0) |=> (count_reg == '0))
    else $error("kmd_core: settle counter restarted without a change");

    // bounce only flagged alongside a counter restart
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && result.bounce_seen) |-> changed && !commit || (passes_reg <= 8'd1))
    else $error("kmd_core: bounce flagged inconsistently");

endmodule

/* hw/rtl/key_matrix_debounce.sv */
// ----------------------------------------------------------------------------
// key_matrix_debounce
// Debounced keyboard matrix: row samples in, stable matrix reports out.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one sampled row per request:
// row_index, active-low column_pins_n, pass_end on the last row of a pass
// and query_column. Each request gives exactly one result on the output
// channel (out_valid / out_stall): stable_row, key_on, settled,
// bounce_seen and pressed_total, all taken after that row's update.
// Requests are registered on entry, processed in a single pass and the
// result registered on exit: a request passes the entry register and then
// the result register before out_valid rises; throughput one request per
// cycle while the receiver does not stall.
// When the receiver stalls, the result register holds and the entry
// register fills; in_stall rises only when both are occupied and the
// receiver is stalling.
// settle_passes is written through cfg_valid / cfg_ready (always ready);
// write it only while no request is in flight.
// Reset clears both matrices, sets the setting and the counter to 5 and
// empties both registers.
// ----------------------------------------------------------------------------
module key_matrix_debounce (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [kmd_pkg::COUNT_W-1:0]        settle_passes,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [kmd_pkg::ROW_W-1:0]          row_index,
    input  logic [kmd_pkg::COL_W-1:0]          column_pins_n,
    input  logic                               pass_end,
    input  logic [kmd_pkg::QCOL_W-1:0]         query_column,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [kmd_pkg::COL_W-1:0]          stable_row,
    output logic                               key_on,
    output logic                               settled,
    output logic                               bounce_seen,
    output logic [kmd_pkg::TOTAL_W-1:0]        pressed_total
);

    logic                 in_v_reg, in_v_next;
    kmd_pkg::kmd_item_t   item_reg;
    logic                 out_v_reg, out_v_next;
    kmd_pkg::kmd_result_t res_reg;
    kmd_pkg::kmd_result_t res;
    logic                 advance;
    logic                 load;

    assign cfg_ready = 1'b1;
    assign advance   = in_v_reg && (!out_v_reg || !out_stall);
    assign in_stall  = in_v_reg && !advance;
    assign load      = in_valid && !in_stall;

    always_comb
    begin
        in_v_next  = load ? 1'b1 : (advance ? 1'b0 : in_v_reg);
        out_v_next = advance ? 1'b1 : ((out_v_reg && !out_stall) ? 1'b0 : out_v_reg);
    end

    kmd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (settle_passes),
        .advance   (advance),
        .item      (item_reg),
        .result    (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            in_v_reg  <= in_v_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.row_index     <= row_index;
            item_reg.column_pins_n <= column_pins_n;
            item_reg.pass_end      <= pass_end;
            item_reg.query_column  <= query_column;
        end
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign out_valid     = out_v_reg;
    assign stable_row    = res_reg.stable_row;
    assign key_on        = res_reg.key_on;
    assign settled       = res_reg.settled;
    assign bounce_seen   = res_reg.bounce_seen;
    assign pressed_total = res_reg.pressed_total;

    // a processed request always lands in the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_v_reg)
    else $error("key_matrix_debounce: processed request lost");

endmodule
